>>> rtl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int unsigned FRACTION_BITS_DEFAULT = 15;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    SECTOR_RED_YELLOW    = 3'd0,
    SECTOR_YELLOW_GREEN  = 3'd1,
    SECTOR_GREEN_CYAN    = 3'd2,
    SECTOR_CYAN_BLUE     = 3'd3,
    SECTOR_BLUE_MAGENTA  = 3'd4,
    SECTOR_MAGENTA_RED   = 3'd5
  } sector_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] brightness;
  } in_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } out_t;

  typedef struct packed {
    sector_t     sector;
    logic [15:0] frac;
    logic [15:0] sat;
    logic [15:0] val;
  } work_t;

endpackage

>>> rtl/hsv2rgb_front.sv
module hsv2rgb_front import hsv2rgb_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  in_t   in_hsv,
  output work_t work
);

  localparam logic [31:0] ONE_W = 32'd1 << FRACTION_BITS;

  logic [18:0] hue6;

  always_comb begin
    hue6 = 19'({in_hsv.hue, 2'b00}) + 19'({in_hsv.hue, 1'b0});
    work.sector = sector_t'(hue6[18:16]);
    work.frac   = hue6[15:0];
    if (32'(in_hsv.saturation) > ONE_W) begin
      work.sat = ONE_W[15:0];
    end else begin
      work.sat = in_hsv.saturation;
    end
    if (32'(in_hsv.brightness) > ONE_W) begin
      work.val = ONE_W[15:0];
    end else begin
      work.val = in_hsv.brightness;
    end
  end

endmodule

>>> rtl/hsv2rgb_queue.sv
module hsv2rgb_queue import hsv2rgb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  output logic  head_valid,
  output work_t head_data
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  work_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           pop;

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign pop        = head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/hsv2rgb_back.sv
module hsv2rgb_back import hsv2rgb_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  work_valid,
  input  work_t work,
  output logic  out_valid,
  output out_t  out_rgba
);

  localparam int unsigned LW = FRACTION_BITS + 1;
  localparam int unsigned PW = 16 + LW;
  localparam logic [LW-1:0] ONE_L = LW'(1) << FRACTION_BITS;
  localparam logic [31:0] ONE_W = 32'd1 << FRACTION_BITS;
  localparam logic [15:0] ALPHA = ONE_W[15:0];

  logic        s1_valid_r;
  sector_t     s1_sector_r;
  logic [15:0] s1_val_r, s1_sat_r, s1_aq_r, s1_at_r;

  logic        s2_valid_r;
  sector_t     s2_sector_r;
  logic [15:0] s2_val_r, s2_p_r, s2_q_r, s2_t_r;

  logic        out_valid_r;
  out_t        out_rgba_r, out_rgba_nxt;

  logic [31:0] prod_q;
  logic [16:0] frac_c;
  logic [32:0] prod_t;
  logic [PW-1:0] prod_p2, prod_q2, prod_t2;

  always_comb begin
    frac_c = 17'h10000 - 17'(work.frac);
    prod_q = 32'(work.sat) * 32'(work.frac);
    prod_t = 33'(work.sat) * 33'(frac_c);
  end

  always_ff @(posedge clk) begin
    s1_sector_r <= work.sector;
    s1_val_r    <= work.val;
    s1_sat_r    <= work.sat;
    s1_aq_r     <= prod_q[31:16];
    s1_at_r     <= prod_t[31:16];
  end

  always_comb begin
    prod_p2 = PW'(s1_val_r) * PW'(ONE_L - LW'(s1_sat_r));
    prod_q2 = PW'(s1_val_r) * PW'(ONE_L - LW'(s1_aq_r));
    prod_t2 = PW'(s1_val_r) * PW'(ONE_L - LW'(s1_at_r));
  end

  always_ff @(posedge clk) begin
    s2_sector_r <= s1_sector_r;
    s2_val_r    <= s1_val_r;
    s2_p_r      <= prod_p2[FRACTION_BITS +: 16];
    s2_q_r      <= prod_q2[FRACTION_BITS +: 16];
    s2_t_r      <= prod_t2[FRACTION_BITS +: 16];
  end

  always_comb begin
    out_rgba_nxt.alpha = ALPHA;
    case (s2_sector_r)
      SECTOR_RED_YELLOW: begin
        out_rgba_nxt.red   = s2_val_r;
        out_rgba_nxt.green = s2_t_r;
        out_rgba_nxt.blue  = s2_p_r;
      end
      SECTOR_YELLOW_GREEN: begin
        out_rgba_nxt.red   = s2_q_r;
        out_rgba_nxt.green = s2_val_r;
        out_rgba_nxt.blue  = s2_p_r;
      end
      SECTOR_GREEN_CYAN: begin
        out_rgba_nxt.red   = s2_p_r;
        out_rgba_nxt.green = s2_val_r;
        out_rgba_nxt.blue  = s2_t_r;
      end
      SECTOR_CYAN_BLUE: begin
        out_rgba_nxt.red   = s2_p_r;
        out_rgba_nxt.green = s2_q_r;
        out_rgba_nxt.blue  = s2_val_r;
      end
      SECTOR_BLUE_MAGENTA: begin
        out_rgba_nxt.red   = s2_t_r;
        out_rgba_nxt.green = s2_p_r;
        out_rgba_nxt.blue  = s2_val_r;
      end
      default: begin
        out_rgba_nxt.red   = s2_val_r;
        out_rgba_nxt.green = s2_p_r;
        out_rgba_nxt.blue  = s2_q_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_rgba_r <= out_rgba_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= work_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rgba  = out_rgba_r;

endmodule

>>> rtl/hsv_to_rgb_convert.sv
// Channel   Ports                      Transfer when
// input     start, busy, in_hsv        start high and busy low at a rising edge
// result    out_valid, out_rgba        out_valid high at a rising edge
//
// One color is accepted per clock.
// A result passes through the work queue and then the three register stages of the back end.
// Reset is synchronous and active low; it empties the queue and clears all valid flags.
// The receiver cannot stall, so the back end drains the queue every cycle and busy stays low.
module hsv_to_rgb_convert import hsv2rgb_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_hsv,
  output logic out_valid,
  output out_t out_rgba
);

  work_t front_work;
  work_t head_work;
  logic  head_valid;
  logic  queue_full;
  logic  accept;

  assign busy   = queue_full;
  assign accept = start && !busy;

  hsv2rgb_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .in_hsv (in_hsv),
    .work   (front_work)
  );

  hsv2rgb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (front_work),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_data  (head_work)
  );

  hsv2rgb_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .work_valid (head_valid),
    .work       (head_work),
    .out_valid  (out_valid),
    .out_rgba   (out_rgba)
  );

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("work queue filled although the back end never stalls");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("accepted color did not produce a result four cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 4))
    else $error("result strobe without a matching input transfer");

endmodule
